/* design/kplq_pkg.sv */
// Package for the key press latch queue: sizes, request codes, types.
`timescale 1ns / 1ps

package kplq_pkg;

    localparam int KeyCount   = 256;
    localparam int QueueDepth = 16;
    localparam int KeyW       = $clog2(KeyCount);
    localparam int QIdxW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic [2:0] REQ_POLL  = 3'd0;
    localparam logic [2:0] REQ_HOOK  = 3'd1;
    localparam logic [2:0] REQ_DRAIN = 3'd2;
    localparam logic [2:0] REQ_MERGE = 3'd3;
    localparam logic [2:0] REQ_GATE  = 3'd4;
    localparam logic [2:0] REQ_CLEAR = 3'd5;
    localparam logic [2:0] REQ_SEED  = 3'd6;

    localparam logic [2:0] CFG_FIX      = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE = 3'd1;
    localparam logic [2:0] CFG_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_MAXAGE   = 3'd3;
    localparam logic [2:0] CFG_HOLD     = 3'd4;

    // Per-key memory word: prev, last press time, hold valid, hold start, force.
    typedef struct packed {
        logic        prev;
        logic [31:0] last_time;
        logic        hold_valid;
        logic [31:0] hold_start;
        logic        force_once;
    } key_rec_t;

    localparam int KeyRecW = $bits(key_rec_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_KREAD,
        ST_KWAIT,
        ST_SCAN,
        ST_APPEND,
        ST_DRAIN,
        ST_DRAIN_RD,
        ST_DRAIN_WR,
        ST_OUT
    } state_t;

    function automatic logic is_keyboard(input logic [7:0] k);
        return !((k >= 8'h01 && k <= 8'h06) || k == 8'hE0 || k == 8'hE1);
    endfunction

endpackage

/* design/kplq_ram.sv */
// Generic single-port-write, single-read RAM with a registered read.
`timescale 1ns / 1ps

module kplq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/key_press_latch_queue_top.sv */
// Top level of the key press latch queue.
// A gate set, an undefined request or a drain with the fix off goes straight to its result;
// poll, hook, merge and seed first read the key record. A press then searches the queue
// entry by entry, appending the key if absent; a drain walks each entry and its key record.
// Throughput: one request at a time, the next taken the cycle after the result is taken.
// Reset runs a pass zeroing the per-key memory (requests wait, configuration writes do
// not); a clear request walks it read-modify-write before it answers.
`timescale 1ns / 1ps

module key_press_latch_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // req_type[2:0], key_code[10:3], level_bit[11],
                                   // is_injected[12], in_foreground[13], time_now[45:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // level_out[0], press_taken[1], folded_count[6:2]
);

    logic        fix_reg;
    logic [15:0] deb_reg;
    logic [4:0]  lim_reg;
    logic [15:0] age_reg;
    logic [15:0] hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_reg  <= 1'b0;
            deb_reg  <= 16'd30;
            lim_reg  <= 5'd8;
            age_reg  <= 16'd250;
            hold_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kplq_pkg::CFG_FIX:      fix_reg  <= cfg_data[0];
                kplq_pkg::CFG_DEBOUNCE: deb_reg  <= cfg_data;
                kplq_pkg::CFG_LIMIT:    lim_reg  <= cfg_data[4:0];
                kplq_pkg::CFG_MAXAGE:   age_reg  <= cfg_data;
                kplq_pkg::CFG_HOLD:     hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kplq_pkg::state_t state_reg, state_next;

    // Latched request.
    logic [2:0]  req_reg;
    logic [7:0]  key_reg;
    logic        lv_reg, inj_reg, fg_reg;
    logic [31:0] t_reg;

    logic        gate_reg, gate_next;
    logic [kplq_pkg::QCntW-1:0] fill_reg, fill_next;
    logic [kplq_pkg::QIdxW-1:0] head_reg, head_next;  // circular queue head
    logic [kplq_pkg::QCntW-1:0] idx_reg, idx_next;
    logic [kplq_pkg::KeyW-1:0]  clr_reg, clr_next;
    logic        clr_done_reg, clr_done_next;
    logic        lvl_reg, lvl_next, tak_reg, tak_next;
    logic [4:0]  fold_reg, fold_next;
    kplq_pkg::key_rec_t rec_reg, rec_next;

    // Key memory.
    logic                       k_we;
    logic [kplq_pkg::KeyW-1:0]  k_waddr, k_raddr;
    kplq_pkg::key_rec_t         k_wdata, k_rdata;

    kplq_ram #(.Width(kplq_pkg::KeyRecW), .Depth(kplq_pkg::KeyCount)) u_key_ram (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .raddr(k_raddr), .rdata(k_rdata)
    );

    // Queue memory: {key, time}.
    logic                       q_we;
    logic [kplq_pkg::QIdxW-1:0] q_waddr, q_raddr;
    logic [39:0]                q_wdata, q_rdata;

    kplq_ram #(.Width(40), .Depth(kplq_pkg::QueueDepth)) u_queue_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    logic [kplq_pkg::QIdxW-1:0] slot;
    logic [kplq_pkg::QCntW-1:0] lim_sat;
    logic                       press_ok;
    logic [31:0]                age;
    logic [31:0]                hage;

    assign s_tready = (state_reg == kplq_pkg::ST_IDLE) && clr_done_reg;
    assign m_tvalid = (state_reg == kplq_pkg::ST_OUT);
    assign m_tdata  = {1'b0, fold_reg, tak_reg, lvl_reg};

    assign lim_sat = (lim_reg > 5'(kplq_pkg::QueueDepth)) ?
                     kplq_pkg::QCntW'(kplq_pkg::QueueDepth) : kplq_pkg::QCntW'(lim_reg);
    assign slot = head_reg + kplq_pkg::QIdxW'(idx_reg);
    assign age  = t_reg - q_rdata[31:0];
    assign hage = t_reg - k_rdata.hold_start;

    // Press admission on the freshly read key record (edge test for poll).
    always_comb
    begin
        press_ok = kplq_pkg::is_keyboard(key_reg) && gate_reg && fg_reg &&
                   !(deb_reg != 16'd0 && (t_reg - k_rdata.last_time) < {16'd0, deb_reg});
        if (req_reg == kplq_pkg::REQ_POLL)
        begin
            press_ok = press_ok && lv_reg && !k_rdata.prev;
        end
        else
        begin
            press_ok = press_ok && lv_reg && !inj_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kplq_pkg::ST_CLEAR;
            gate_reg     <= 1'b1;
            fill_reg     <= '0;
            head_reg     <= '0;
            idx_reg      <= '0;
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            gate_reg     <= gate_next;
            fill_reg     <= fill_next;
            head_reg     <= head_next;
            idx_reg      <= idx_next;
            clr_reg      <= clr_next;
            clr_done_reg <= clr_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg <= s_tdata[2:0];
            key_reg <= s_tdata[10:3];
            lv_reg  <= s_tdata[11];
            inj_reg <= s_tdata[12];
            fg_reg  <= s_tdata[13];
            t_reg   <= s_tdata[45:14];
        end
        lvl_reg  <= lvl_next;
        tak_reg  <= tak_next;
        fold_reg <= fold_next;
        rec_reg  <= rec_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kplq_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    case (s_tdata[2:0])
                        kplq_pkg::REQ_POLL, kplq_pkg::REQ_HOOK,
                        kplq_pkg::REQ_MERGE, kplq_pkg::REQ_SEED:
                            state_next = kplq_pkg::ST_KREAD;
                        kplq_pkg::REQ_DRAIN:
                            state_next = s_tdata[2:0] == kplq_pkg::REQ_DRAIN && fix_reg ?
                                         kplq_pkg::ST_DRAIN : kplq_pkg::ST_OUT;
                        kplq_pkg::REQ_CLEAR:
                            state_next = kplq_pkg::ST_CLEAR;
                        default:
                            state_next = kplq_pkg::ST_OUT;
                    endcase
                end
            end
            kplq_pkg::ST_CLEAR:
            begin
                // A clear request leaves only after the write of the last entry.
                if (clr_reg == '1 && (!clr_done_reg || rec_reg.prev))
                begin
                    state_next = clr_done_reg ? kplq_pkg::ST_OUT : kplq_pkg::ST_IDLE;
                end
            end
            kplq_pkg::ST_KREAD:
                state_next = kplq_pkg::ST_KWAIT;
            kplq_pkg::ST_KWAIT:
            begin
                if ((req_reg == kplq_pkg::REQ_POLL || req_reg == kplq_pkg::REQ_HOOK) &&
                    press_ok)
                begin
                    state_next = kplq_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = kplq_pkg::ST_OUT;
                end
            end
            kplq_pkg::ST_SCAN:
            begin
                // Queue read for idx_reg-1 is available; idx_reg counts issued reads.
                if (idx_reg != '0 && q_rdata[39:32] == key_reg)
                begin
                    state_next = kplq_pkg::ST_OUT;
                end
                else if (idx_reg == fill_reg)
                begin
                    state_next = kplq_pkg::ST_APPEND;
                end
            end
            kplq_pkg::ST_APPEND:
                state_next = kplq_pkg::ST_OUT;
            kplq_pkg::ST_DRAIN:
                state_next = (idx_reg == fill_reg) ? kplq_pkg::ST_OUT :
                             kplq_pkg::ST_DRAIN_RD;
            kplq_pkg::ST_DRAIN_RD:
                state_next = kplq_pkg::ST_DRAIN_WR;
            kplq_pkg::ST_DRAIN_WR:
                state_next = kplq_pkg::ST_DRAIN;
            kplq_pkg::ST_OUT:
                state_next = m_tready ? kplq_pkg::ST_IDLE : kplq_pkg::ST_OUT;
            default:
                state_next = kplq_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        gate_next     = gate_reg;
        fill_next     = fill_reg;
        head_next     = head_reg;
        idx_next      = idx_reg;
        clr_next      = clr_reg;
        clr_done_next = clr_done_reg;
        lvl_next      = lvl_reg;
        tak_next      = tak_reg;
        fold_next     = fold_reg;
        rec_next      = rec_reg;
        k_we          = 1'b0;
        k_waddr       = key_reg;
        k_wdata       = k_rdata;
        k_raddr       = key_reg;
        q_we          = 1'b0;
        q_waddr       = slot;
        q_wdata       = {key_reg, t_reg};
        q_raddr       = slot;
        case (state_reg)
            kplq_pkg::ST_IDLE:
            begin
                idx_next  = '0;
                clr_next  = '0;
                lvl_next  = 1'b0;
                tak_next  = 1'b0;
                fold_next = '0;
                // A clear pass starts in its read phase.
                rec_next.prev = 1'b0;
                if (s_tvalid && s_tready)
                begin
                    case (s_tdata[2:0])
                        kplq_pkg::REQ_GATE:
                        begin
                            gate_next = s_tdata[11];
                            if (!s_tdata[11])
                            begin
                                fill_next = '0;
                            end
                        end
                        kplq_pkg::REQ_CLEAR:
                            fill_next = '0;
                        default: ;
                    endcase
                end
            end
            kplq_pkg::ST_CLEAR:
            begin
                // After reset everything is zeroed; a clear request keeps prev,
                // last press time and hold start, so that pass reads first.
                k_raddr = clr_reg + 1'b1;
                k_waddr = clr_reg;
                k_we    = 1'b1;
                if (clr_done_reg)
                begin
                    // The registered read delays clr_reg's data; use a read-before-write pass
                    // by holding the address through a read phase and a write phase.
                    k_raddr = clr_reg;
                    k_we    = rec_reg.prev; // phase marker reused below
                    k_wdata = k_rdata;
                    k_wdata.hold_valid = 1'b0;
                    k_wdata.force_once = 1'b0;
                    rec_next.prev = !rec_reg.prev;
                    if (rec_reg.prev)
                    begin
                        clr_next = clr_reg + 1'b1;
                    end
                    else
                    begin
                        k_we = 1'b0;
                    end
                end
                else
                begin
                    k_wdata  = '0;
                    clr_next = clr_reg + 1'b1;
                    if (clr_reg == '1)
                    begin
                        clr_done_next = 1'b1;
                    end
                end
            end
            kplq_pkg::ST_KREAD:
            begin
                k_raddr = key_reg;
                q_raddr = head_reg;
            end
            kplq_pkg::ST_KWAIT:
            begin
                rec_next = k_rdata;
                case (req_reg)
                    kplq_pkg::REQ_POLL, kplq_pkg::REQ_HOOK:
                    begin
                        if (req_reg == kplq_pkg::REQ_POLL && kplq_pkg::is_keyboard(key_reg))
                        begin
                            k_we          = 1'b1;
                            k_wdata.prev  = lv_reg;
                        end
                        if (press_ok)
                        begin
                            k_we             = 1'b1;
                            k_wdata.last_time = t_reg;
                            tak_next          = 1'b1;
                            q_raddr           = head_reg;
                            idx_next          = '0;
                        end
                    end
                    kplq_pkg::REQ_MERGE:
                    begin
                        lvl_next = lv_reg;
                        if (fix_reg)
                        begin
                            k_we = 1'b1;
                            if (k_rdata.force_once)
                            begin
                                lvl_next = 1'b1;
                            end
                            k_wdata.force_once = 1'b0;
                            if (hold_reg != 16'd0 && k_rdata.hold_valid)
                            begin
                                if (hage < {16'd0, hold_reg})
                                begin
                                    lvl_next = 1'b1;
                                end
                                else
                                begin
                                    k_wdata.hold_valid = 1'b0;
                                end
                            end
                        end
                    end
                    kplq_pkg::REQ_SEED:
                    begin
                        k_we    = 1'b1;
                        k_wdata = '0;
                        k_wdata.prev = lv_reg;
                    end
                    default: ;
                endcase
            end
            kplq_pkg::ST_SCAN:
            begin
                // Issue read of entry idx_reg; compare the previous one.
                if (idx_reg != '0 && q_rdata[39:32] == key_reg)
                begin
                    q_we    = 1'b1;
                    q_waddr = head_reg + kplq_pkg::QIdxW'(idx_reg - 1'b1);
                end
                else if (idx_reg != fill_reg)
                begin
                    q_raddr  = slot;
                    idx_next = idx_reg + 1'b1;
                end
            end
            kplq_pkg::ST_APPEND:
            begin
                // Write at head+fill, then trim from the head down to the limit.
                q_we    = 1'b1;
                q_waddr = head_reg + kplq_pkg::QIdxW'(fill_reg);
                if (fill_reg >= lim_sat)
                begin
                    // fill+1 entries, keep lim_sat of them
                    head_next = head_reg + kplq_pkg::QIdxW'(fill_reg + 1'b1 - lim_sat);
                    fill_next = lim_sat;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            kplq_pkg::ST_DRAIN:
            begin
                q_raddr = slot;
                if (idx_reg == fill_reg)
                begin
                    fill_next = '0;
                end
            end
            kplq_pkg::ST_DRAIN_RD:
            begin
                k_raddr = q_rdata[39:32];
                rec_next.last_time = q_rdata[31:0];
                rec_next.prev = (age <= {16'd0, age_reg});
                rec_next.hold_start = {24'd0, q_rdata[39:32]};
            end
            kplq_pkg::ST_DRAIN_WR:
            begin
                k_waddr = rec_reg.hold_start[7:0];
                k_wdata = k_rdata;
                k_wdata.force_once = 1'b1;
                k_wdata.hold_valid = 1'b1;
                k_wdata.hold_start = t_reg;
                k_we     = rec_reg.prev;
                idx_next = idx_reg + 1'b1;
                if (rec_reg.prev)
                begin
                    fold_next = fold_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

/* design/kplq_checker.sv */
// Port-level checker for the key press latch queue, bound to the top level.
`timescale 1ns / 1ps

module kplq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // A result never overlaps a new request being taken.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("request taken while a result is pending");

    // A held result keeps its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A press and a folded count never come from one request.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[6:2] != 5'd0))
        else $error("press and drain count together");

    // Folded count stays within the queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:2] <= 5'd16)
        else $error("folded count beyond queue depth");

endmodule

bind key_press_latch_queue_top kplq_checker u_kplq_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

/* sim/tb.sv */
// Self-checking testbench for the key press latch queue.
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] REQ_UNDEF = 3'd7;

    typedef struct packed {
        logic [31:0] time_now;
        logic        in_fg;
        logic        injected;
        logic        level;
        logic [7:0]  key;
        logic [2:0]  req;
    } key_req_t;

    typedef struct packed {
        logic [4:0] folded;
        logic       taken;
        logic       level_out;
    } key_rsp_t;

    typedef struct {
        key_req_t r;
        logic     fixed;
        key_rsp_t rsp;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = kplq_pkg::CFG_FIX;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    key_press_latch_queue_top DUT (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state.
    logic        p_fix;
    logic [15:0] p_debounce, p_max_age, p_hold_win;
    logic [4:0]  p_limit;
    logic        p_prev [256];
    logic [31:0] p_last [256];
    logic        p_hvalid [256];
    logic [31:0] p_hstart [256];
    logic        p_force [256];
    logic [7:0]  q_key [$];
    logic [31:0] q_time [$];
    logic        p_gate;

    key_rsp_t rsp_pending [$];
    int       err_count = 0;
    int       send_idle = 0;
    int       recv_stall = 0;
    logic     hold_off = 1'b0;
    logic [31:0] clock_ms = 32'd1000;

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        err_count++;
    endtask

    function automatic logic keyboard_code(input logic [7:0] k);
        return !((k >= 8'h01 && k <= 8'h06) || k == 8'hE0 || k == 8'hE1);
    endfunction

    function automatic logic latch_press(input logic [7:0] k, input logic fg,
                                         input logic [31:0] t);
        int lim;
        if (!keyboard_code(k) || !p_gate || !fg) return 1'b0;
        if (p_debounce != 0 && (t - p_last[k]) < {16'd0, p_debounce}) return 1'b0;
        p_last[k] = t;
        foreach (q_key[i])
            if (q_key[i] == k)
            begin
                q_time[i] = t;
                return 1'b1;
            end
        if (q_key.size() >= kplq_pkg::QueueDepth)
        begin
            void'(q_key.pop_front());
            void'(q_time.pop_front());
        end
        q_key.insert(q_key.size(), k);
        q_time.insert(q_time.size(), t);
        lim = (p_limit > kplq_pkg::QueueDepth) ? kplq_pkg::QueueDepth : int'(p_limit);
        while (q_key.size() > lim)
        begin
            void'(q_key.pop_front());
            void'(q_time.pop_front());
        end
        return 1'b1;
    endfunction

    function automatic key_rsp_t predict_latch(input key_req_t r);
        key_rsp_t o;
        o = '0;
        case (r.req)
            kplq_pkg::REQ_POLL:
                if (keyboard_code(r.key))
                begin
                    if (r.level && !p_prev[r.key]) o.taken = latch_press(r.key, r.in_fg, r.time_now);
                    p_prev[r.key] = r.level;
                end
            kplq_pkg::REQ_HOOK:
                if (r.level && !r.injected) o.taken = latch_press(r.key, r.in_fg, r.time_now);
            kplq_pkg::REQ_DRAIN:
                if (p_fix)
                begin
                    foreach (q_key[i])
                        if ((r.time_now - q_time[i]) <= {16'd0, p_max_age})
                        begin
                            p_force[q_key[i]] = 1'b1;
                            p_hvalid[q_key[i]] = 1'b1;
                            p_hstart[q_key[i]] = r.time_now;
                            o.folded++;
                        end
                    q_key.delete();
                    q_time.delete();
                end
            kplq_pkg::REQ_MERGE:
            begin
                o.level_out = r.level;
                if (p_fix)
                begin
                    if (p_force[r.key]) o.level_out = 1'b1;
                    p_force[r.key] = 1'b0;
                    if (p_hold_win != 0 && p_hvalid[r.key])
                    begin
                        if ((r.time_now - p_hstart[r.key]) < {16'd0, p_hold_win})
                            o.level_out = 1'b1;
                        else
                            p_hvalid[r.key] = 1'b0;
                    end
                end
            end
            kplq_pkg::REQ_GATE:
            begin
                p_gate = r.level;
                if (!r.level)
                begin
                    q_key.delete();
                    q_time.delete();
                end
            end
            kplq_pkg::REQ_CLEAR:
            begin
                q_key.delete();
                q_time.delete();
                foreach (p_hvalid[i])
                begin
                    p_hvalid[i] = 1'b0;
                    p_force[i] = 1'b0;
                end
            end
            kplq_pkg::REQ_SEED:
            begin
                p_prev[r.key] = r.level;
                p_last[r.key] = '0;
                p_hvalid[r.key] = 1'b0;
                p_hstart[r.key] = '0;
                p_force[r.key] = 1'b0;
            end
            default: ;
        endcase
        return o;
    endfunction

    // The extra cycle keeps back-to-back writes from driving cfg_we twice in one step.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            kplq_pkg::CFG_FIX:      p_fix = val[0];
            kplq_pkg::CFG_DEBOUNCE: p_debounce = val;
            kplq_pkg::CFG_LIMIT:    p_limit = val[4:0];
            kplq_pkg::CFG_MAXAGE:   p_max_age = val;
            kplq_pkg::CFG_HOLD:     p_hold_win = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (rsp_pending.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Sends one request; with send_idle at zero, tvalid stays high between requests.
    task automatic send_req(input key_req_t r);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        rsp_pending.insert(rsp_pending.size(), predict_latch(r));
    endtask

    function automatic logic [7:0] pick_key();
        int c;
        c = $urandom_range(99);
        if (c < 70) return 8'(8'h41 + $urandom_range(7));
        if (c < 80) return 8'($urandom_range(1, 6));
        if (c < 85) return 8'(8'hE0 + $urandom_range(1));
        return 8'($urandom_range(255));
    endfunction

    function automatic key_req_t rand_req();
        key_req_t r;
        int c;
        c = $urandom_range(99);
        r.key = pick_key();
        r.level = 1'($urandom_range(1));
        r.injected = ($urandom_range(9) == 0);
        r.in_fg = ($urandom_range(9) != 0);
        clock_ms = clock_ms + $urandom_range(40);
        r.time_now = clock_ms;
        if (c < 30) r.req = kplq_pkg::REQ_POLL;
        else if (c < 55) r.req = kplq_pkg::REQ_HOOK;
        else if (c < 65) r.req = kplq_pkg::REQ_DRAIN;
        else if (c < 88) r.req = kplq_pkg::REQ_MERGE;
        else if (c < 91) r.req = kplq_pkg::REQ_GATE;
        else if (c < 93) r.req = kplq_pkg::REQ_CLEAR;
        else if (c < 97) r.req = kplq_pkg::REQ_SEED;
        else
        begin
            r.req = REQ_UNDEF;
            r.time_now = $urandom();
        end
        if (r.req == kplq_pkg::REQ_GATE && $urandom_range(3) != 0) r.level = 1'b1;
        return r;
    endfunction

    // Output checker and receiver stalls.
    always @(posedge clk)
    begin
        key_rsp_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[6:0];
            if (rsp_pending.size() == 0)
                report("unexpected response", m_tdata, 8'h00);
            else
            begin
                want = rsp_pending.pop_front();
                if (got.level_out !== want.level_out)
                    report("level_out", 8'(got.level_out), 8'(want.level_out));
                if (got.taken !== want.taken)
                    report("press_taken", 8'(got.taken), 8'(want.taken));
                if (got.folded !== want.folded)
                    report("folded_count", 8'(got.folded), 8'(want.folded));
            end
        end
        m_tready <= !hold_off && !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    dir_row_t dir_rows [$];

    initial
    begin
        key_req_t r;
        dir_row_t d;
        logic [31:0] tmax;
        p_fix = 1'b0; p_debounce = 16'd30; p_limit = 5'd8; p_max_age = 16'd250;
        p_hold_win = 16'd0; p_gate = 1'b1;
        foreach (p_prev[i])
        begin
            p_prev[i] = 0; p_last[i] = 0; p_hvalid[i] = 0; p_hstart[i] = 0; p_force[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: row = request, then an expected response where obvious.
        tmax = 32'hFFFF_FFFF;
        dir_rows = '{
            '{'{32'd10, 1'b1, 1'b0, 1'b1, 8'h41, kplq_pkg::REQ_HOOK}, 1'b1, 7'b0000000},
            '{'{32'd100, 1'b1, 1'b0, 1'b1, 8'h41, kplq_pkg::REQ_POLL}, 1'b0, '0},
            '{'{32'd100, 1'b1, 1'b0, 1'b1, 8'h01, kplq_pkg::REQ_POLL}, 1'b1, 7'b0000000},
            '{'{32'd100, 1'b1, 1'b0, 1'b1, 8'hE1, kplq_pkg::REQ_HOOK}, 1'b1, 7'b0000000},
            '{'{32'd200, 1'b1, 1'b1, 1'b1, 8'h42, kplq_pkg::REQ_HOOK}, 1'b1, 7'b0000000},
            '{'{32'd200, 1'b0, 1'b0, 1'b1, 8'h43, kplq_pkg::REQ_HOOK}, 1'b1, 7'b0000000},
            '{'{32'd200, 1'b1, 1'b0, 1'b1, 8'hFF, kplq_pkg::REQ_HOOK}, 1'b0, '0},
            '{'{32'd210, 1'b1, 1'b0, 1'b1, 8'hFF, kplq_pkg::REQ_HOOK}, 1'b1, 7'b0000000},
            '{'{32'd300, 1'b1, 1'b0, 1'b1, 8'h00, kplq_pkg::REQ_HOOK}, 1'b0, '0},
            '{'{32'd300, 1'b1, 1'b0, 1'b1, 8'h00, kplq_pkg::REQ_MERGE}, 1'b1, 7'b0000001},
            '{'{32'd300, 1'b1, 1'b0, 1'b0, 8'h00, kplq_pkg::REQ_MERGE}, 1'b1, 7'b0000000},
            '{'{32'd300, 1'b1, 1'b0, 1'b0, 8'h00, kplq_pkg::REQ_DRAIN}, 1'b1, 7'b0000000},
            '{'{tmax, 1'b1, 1'b1, 1'b1, 8'hFF, REQ_UNDEF}, 1'b1, 7'b0000000},
            '{'{32'd400, 1'b1, 1'b0, 1'b0, 8'h00, kplq_pkg::REQ_GATE}, 1'b1, 7'b0000000},
            '{'{32'd500, 1'b1, 1'b0, 1'b1, 8'h44, kplq_pkg::REQ_HOOK}, 1'b1, 7'b0000000},
            '{'{32'd500, 1'b1, 1'b0, 1'b1, 8'h00, kplq_pkg::REQ_GATE}, 1'b1, 7'b0000000},
            '{'{32'd600, 1'b1, 1'b0, 1'b1, 8'h44, kplq_pkg::REQ_SEED}, 1'b0, '0},
            '{'{32'd600, 1'b1, 1'b0, 1'b0, 8'h44, kplq_pkg::REQ_POLL}, 1'b0, '0},
            '{'{32'd700, 1'b1, 1'b0, 1'b1, 8'h44, kplq_pkg::REQ_HOOK}, 1'b0, '0},
            '{'{32'd0, 1'b1, 1'b0, 1'b0, 8'h00, kplq_pkg::REQ_CLEAR}, 1'b1, 7'b0000000}
        };
        foreach (dir_rows[i])
        begin
            d = dir_rows[i];
            send_req(d.r);
            if (d.fixed && rsp_pending[$] != d.rsp)
                report("predictor row", {1'b0, rsp_pending[$]}, {1'b0, d.rsp});
        end
        wait_idle();

        // Fix enabled: drain, force and hold, extremes of the limit.
        write_reg(kplq_pkg::CFG_FIX, 16'd1);
        write_reg(kplq_pkg::CFG_HOLD, 16'hFFFF);
        write_reg(kplq_pkg::CFG_LIMIT, 16'd31);
        write_reg(kplq_pkg::CFG_MAXAGE, 16'hFFFF);
        write_reg(kplq_pkg::CFG_DEBOUNCE, 16'd0);
        for (int k = 0; k < 20; k++)
        begin
            r = '{32'd2000, 1'b1, 1'b0, 1'b1, 8'(k + 'h30), kplq_pkg::REQ_HOOK};
            send_req(r);
        end
        send_req('{32'd2005, 1'b1, 1'b0, 1'b0, 8'h00, kplq_pkg::REQ_DRAIN});
        send_req('{32'd2006, 1'b1, 1'b0, 1'b0, 8'h3F, kplq_pkg::REQ_MERGE});
        send_req('{32'd2006, 1'b1, 1'b0, 1'b0, 8'h3F, kplq_pkg::REQ_MERGE});
        wait_idle();
        write_reg(kplq_pkg::CFG_LIMIT, 16'd0);
        send_req('{32'd2100, 1'b1, 1'b0, 1'b1, 8'h50, kplq_pkg::REQ_HOOK});
        send_req('{32'd2100, 1'b1, 1'b0, 1'b0, 8'h00, kplq_pkg::REQ_DRAIN});
        wait_idle();

        // Random phases over several settings and idle mixes.
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            write_reg(kplq_pkg::CFG_FIX, (ph == 1) ? 16'd0 : 16'd1);
            write_reg(kplq_pkg::CFG_DEBOUNCE, (ph == 2) ? 16'hFFFF : 16'($urandom_range(60)));
            write_reg(kplq_pkg::CFG_LIMIT, (ph == 3) ? 16'd1 : 16'($urandom_range(2, 17)));
            write_reg(kplq_pkg::CFG_MAXAGE, (ph == 4) ? 16'd0 : 16'($urandom_range(20, 400)));
            write_reg(kplq_pkg::CFG_HOLD, (ph == 5) ? 16'd0 : 16'($urandom_range(1, 200)));
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 48; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 48; end
                default: begin send_idle = 30; recv_stall = 30; end
            endcase
            if (ph == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int n = 0; n < 120; n++)
            begin
                // Random mix of requests, mostly over a small set of keys.
                send_req(rand_req());
            end
        end
        wait_idle();
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb: errors");
        $finish;
    end
endmodule

/* filelist.f */
design/kplq_pkg.sv
design/kplq_ram.sv
design/key_press_latch_queue_top.sv
design/kplq_checker.sv
sim/tb.sv
